### rtl/core/dqpb_pkg.sv
// ----------------------------------------------------------------------------
// dqpb_pkg
// Shared types, codes and constants of the DNS query packet builder.
// ----------------------------------------------------------------------------
package dqpb_pkg;

  localparam int MAX_LABEL_DEF  = 63;
  localparam int CMD_DEPTH_DEF  = 2;

  localparam int LEN_W          = 6;
  localparam int KIND_W         = 2;

  localparam logic [7:0]  DOT_CHAR      = 8'h2E;
  localparam logic [15:0] FLAG_RD       = 16'h0100;
  localparam logic [15:0] FLAG_INVERSE  = 16'h0800;
  localparam logic [15:0] FLAG_STATUS   = 16'h1000;

  // query_kind codes
  localparam logic [1:0] QK_STANDARD = 2'd0;
  localparam logic [1:0] QK_INVERSE  = 2'd1;
  localparam logic [1:0] QK_STATUS   = 2'd2;

  // command kinds handed from front to back
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOT   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              last;
    logic [15:0]       data;   // query id, or name char in the low byte
    logic [15:0]       flags;  // header flags word for a start
  } dqpb_cmd_t;

  function automatic logic [15:0] flags_word(input logic [1:0] qk);
    logic [15:0] f;
    f = FLAG_RD;
    case (qk)
      QK_INVERSE: f = FLAG_RD | FLAG_INVERSE;
      QK_STATUS:  f = FLAG_RD | FLAG_STATUS;
      default:    f = FLAG_RD;
    endcase
    return f;
  endfunction

endpackage

### rtl/core/dqpb_fifo.sv
// ----------------------------------------------------------------------------
// dqpb_fifo
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module dqpb_fifo #(
  parameter int DEPTH = dqpb_pkg::CMD_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dqpb_pkg::dqpb_cmd_t push_cmd,
  input  logic                pop,
  output dqpb_pkg::dqpb_cmd_t head_cmd,
  output logic                full,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dqpb_pkg::dqpb_cmd_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/dqpb_front.sv
// ----------------------------------------------------------------------------
// dqpb_front
// Accepts input items, holds the query_kind register and classifies each
// item into a start, name character or dot command for the queue.
// ----------------------------------------------------------------------------
module dqpb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [15:0]         in_query_id,
  input  logic [7:0]          in_name_char,
  input  logic                in_end_of_name,
  input  logic                q_full,
  output logic                q_push,
  output dqpb_pkg::dqpb_cmd_t q_cmd
);

  logic [1:0] query_kind_r, query_kind_nxt;

  assign query_kind_nxt = cfg_we ? cfg_wdata : query_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_kind_r <= dqpb_pkg::QK_STANDARD;
    end else begin
      query_kind_r <= query_kind_nxt;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.flags = dqpb_pkg::flags_word(query_kind_r);
    q_cmd.last  = in_end_of_name;
    if (!in_opcode) begin
      q_cmd.kind = dqpb_pkg::KIND_START;
      q_cmd.data = in_query_id;
      q_cmd.last = 1'b0;
    end else if (in_name_char == dqpb_pkg::DOT_CHAR) begin
      q_cmd.kind = dqpb_pkg::KIND_DOT;
      q_cmd.data = {8'h00, in_name_char};
    end else begin
      q_cmd.kind = dqpb_pkg::KIND_CHAR;
      q_cmd.data = {8'h00, in_name_char};
    end
  end

endmodule

### rtl/core/dqpb_back.sv
// ----------------------------------------------------------------------------
// dqpb_back
// Executes queued commands: header words, label buffering and flush, name
// tail, and packs the byte stream into 16-bit output words.
// ----------------------------------------------------------------------------
module dqpb_back #(
  parameter int MAX_LABEL = dqpb_pkg::MAX_LABEL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  dqpb_pkg::dqpb_cmd_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_packet_word,
  output logic [1:0]          out_valid_bytes,
  output logic                out_packet_end,
  output logic                out_label_too_long
);

  localparam int AW    = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int LEN_W = dqpb_pkg::LEN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_BODY = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;

  localparam logic [2:0] HDR_LAST  = 3'd5;
  localparam logic [2:0] TAIL_LAST = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic             tail_r, tail_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [15:0]      flags_r, flags_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             held_v_r, held_v_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_word_r, out_word_nxt;
  logic [1:0]       out_vb_r, out_vb_nxt;
  logic             out_end_r, out_end_nxt;
  logic             out_ltl_r, out_ltl_nxt;

  logic [7:0]       label_mem [MAX_LABEL];
  logic [7:0]       rd_data_r;
  logic             mem_we;

  // byte/word unit offered to the packer this cycle
  logic             u_valid;
  logic             u_word;
  logic [15:0]      u_data;
  logic             u_last;
  logic             u_acc;
  logic             out_free;
  logic             u_emits;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    u_valid = 1'b0;
    u_word  = 1'b0;
    u_data  = '0;
    u_last  = 1'b0;
    case (state_r)
      S_HDR: begin
        u_valid = 1'b1;
        u_word  = 1'b1;
        case (cnt_r)
          3'd0:    u_data = id_r;
          3'd1:    u_data = flags_r;
          3'd2:    u_data = 16'h0001;
          default: u_data = 16'h0000;
        endcase
      end
      S_LEN: begin
        u_valid = (len_r != '0);
        u_data  = {8'h00, 2'b00, len_r};
      end
      S_BODY: begin
        u_valid = 1'b1;
        u_data  = {8'h00, rd_data_r};
      end
      S_TAIL: begin
        u_valid = 1'b1;
        u_data  = ((cnt_r == 3'd2) || (cnt_r == TAIL_LAST)) ? 16'h0001 : 16'h0000;
        u_last  = (cnt_r == TAIL_LAST);
      end
      default: begin
        u_valid = 1'b0;
      end
    endcase
  end

  // a lone byte that is not last only parks in the held register
  assign u_emits = u_word || held_v_r || u_last;
  assign u_acc   = u_valid && (!u_emits || out_free);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    ovf_nxt    = ovf_r;
    tail_nxt   = tail_r;
    id_nxt     = id_r;
    flags_nxt  = flags_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    mem_we     = 1'b0;
    q_pop      = 1'b0;

    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_vb_nxt    = out_vb_r;
    out_end_nxt   = out_end_r;
    out_ltl_nxt   = out_ltl_r;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.kind)
            dqpb_pkg::KIND_START: begin
              id_nxt     = q_head.data;
              flags_nxt  = q_head.flags;
              len_nxt    = '0;
              held_v_nxt = 1'b0;
              held_nxt   = '0;
              ovf_nxt    = 1'b0;
              cnt_nxt    = '0;
              state_nxt  = S_HDR;
            end
            dqpb_pkg::KIND_CHAR: begin
              if (len_r < LEN_W'(MAX_LABEL)) begin
                mem_we  = 1'b1;
                len_nxt = len_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
              tail_nxt  = q_head.last;
              state_nxt = q_head.last ? S_LEN : S_IDLE;
            end
            default: begin
              tail_nxt  = q_head.last;
              state_nxt = S_LEN;
            end
          endcase
        end
      end
      S_HDR: begin
        if (u_acc) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = (cnt_r == HDR_LAST) ? S_IDLE : S_HDR;
        end
      end
      S_LEN: begin
        idx_nxt = '0;
        if (len_r == '0) begin
          cnt_nxt   = '0;
          state_nxt = tail_r ? S_TAIL : S_IDLE;
        end else if (u_acc) begin
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        if (u_acc) begin
          if ((idx_r + 1'b1) == len_r) begin
            len_nxt   = '0;
            idx_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = tail_r ? S_TAIL : S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_TAIL: begin
        if (u_acc) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = (cnt_r == TAIL_LAST) ? S_IDLE : S_TAIL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // packer
    if (u_acc) begin
      if (u_word) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = u_data;
        out_vb_nxt    = 2'd2;
        out_end_nxt   = 1'b0;
        out_ltl_nxt   = ovf_nxt;
      end else if (held_v_r) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = {held_r, u_data[7:0]};
        out_vb_nxt    = 2'd2;
        out_end_nxt   = u_last;
        out_ltl_nxt   = ovf_r;
        held_v_nxt    = 1'b0;
        held_nxt      = '0;
      end else if (u_last) begin
        // odd length: final byte padded
        out_valid_nxt = 1'b1;
        out_word_nxt  = {u_data[7:0], 8'h00};
        out_vb_nxt    = 2'd1;
        out_end_nxt   = 1'b1;
        out_ltl_nxt   = ovf_r;
      end else begin
        held_nxt   = u_data[7:0];
        held_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      tail_r      <= 1'b0;
      held_r      <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      ovf_r       <= ovf_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    flags_r    <= flags_nxt;
    out_word_r <= out_word_nxt;
    out_vb_r   <= out_vb_nxt;
    out_end_r  <= out_end_nxt;
    out_ltl_r  <= out_ltl_nxt;
  end

  // label store: write on a buffered char, read one entry ahead of the flush
  always_ff @(posedge clk) begin
    if (mem_we) begin
      label_mem[len_r[AW-1:0]] <= q_head.data[7:0];
    end
    rd_data_r <= label_mem[idx_nxt[AW-1:0]];
  end

  assign out_valid          = out_valid_r;
  assign out_packet_word    = out_word_r;
  assign out_valid_bytes    = out_vb_r;
  assign out_packet_end     = out_end_r;
  assign out_label_too_long = out_ltl_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_LABEL))
    else $error("label length beyond MAX_LABEL");

  a_hdr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HDR && u_acc) |=> (out_valid_r && !out_ltl_r && !out_end_r))
    else $error("header word flagged");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (u_acc && u_last) |=> (out_valid_r && out_end_r && !held_v_r))
    else $error("packet end not marked or held byte left over");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && !q_empty))
    else $error("command popped while busy");

endmodule

### rtl/core/dns_query_packet_builder_top.sv
// ----------------------------------------------------------------------------
// dns_query_packet_builder_top
// Builds DNS query packets as big-endian 16-bit words from a start item
// and a dotted name fed one character per item.
// ----------------------------------------------------------------------------
// Items pass the command queue and back sequencer to a registered output.
// The back emits one byte or header word per cycle while out_ready allows;
//   a char is buffered; a flush sends length and label bytes, a start the
//   header, a tail 5 bytes. Front accepts while the 2-entry queue has room.
// Reset (sync, rst_n low): control cleared, query_kind 0; label store
//   contents are not cleared.
module dns_query_packet_builder_top #(
  parameter int MAX_LABEL = dqpb_pkg::MAX_LABEL_DEF,  // 1..63
  parameter int CMD_DEPTH = dqpb_pkg::CMD_DEPTH_DEF   // 2..16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: query_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [15:0] in_query_id,
  input  logic [7:0]  in_name_char,
  input  logic        in_end_of_name,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_packet_word,
  output logic [1:0]  out_valid_bytes,
  output logic        out_packet_end,
  output logic        out_label_too_long
);

  dqpb_pkg::dqpb_cmd_t push_cmd;
  dqpb_pkg::dqpb_cmd_t head_cmd;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  // front: accept + classify, owns query_kind
  dqpb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_query_id    (in_query_id),
    .in_name_char   (in_name_char),
    .in_end_of_name (in_end_of_name),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  // decouples front from the back's multi-cycle work
  dqpb_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: label store, sequencer, word packer, output register
  dqpb_back #(
    .MAX_LABEL (MAX_LABEL)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (head_cmd),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_packet_word    (out_packet_word),
    .out_valid_bytes    (out_valid_bytes),
    .out_packet_end     (out_packet_end),
    .out_label_too_long (out_label_too_long)
  );

endmodule
